### design/fqc_pkg.sv
package fqc_pkg;

  // store geometry
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // port field widths
  localparam int CMD_W   = 2;
  localparam int VAL_W   = 32;
  localparam int PLC_W   = 5;
  localparam int COUNT_W = 5;

  // stream packing
  localparam int S_FIELDS_W = VAL_W + PLC_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 3 * VAL_W + 3 + COUNT_W + 1;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CNT_W:0]   sum_t;
  typedef logic [WIDTH-1:0] elem_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);
  localparam cnt_t FULL_CNT = cnt_t'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_JUMP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // classified operation handed from front to back
  typedef struct packed {
    cmd_t  cmd;
    elem_t value;
    cnt_t  places;
  } op_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == LAST_IDX) ? '0 : i + idx_t'(1);
  endfunction

endpackage

### design/fifo_queue_with_cursor.sv
// bounded fifo of 16 words with a read cursor, driven by a command stream
// input channel s_*: one item per command (enqueue, dequeue, cursor jump, query)
//   s_tuser carries the command code, s_tdata the enqueue value and jump distance
// output channel m_*: exactly one item per command, describing the queue after it:
//   head, tail and cursor elements with their valid flags, entry count and overflow
// front end decodes commands and saturates jump distances, a two-entry command
//   queue decouples it from the back end, which owns the pointers and the store
// path: an accepted command is registered in the command queue, then executed, with the
//   store read, into the output register that drives m_tvalid
// throughput: one command per cycle while m_tready is high, set by the single back end
//   execute stage, which updates pointers and reads head and cursor from the store together
// a full store drops the enqueue and reports overflow; jumps past the tail kill
//   the cursor until the next enqueue into an empty queue
// reset (rst, synchronous) empties the queue and kills the cursor; store contents
//   are left as they are and never reach the output before being written
// when m_tready is low the result is held in the output register; the back end
//   stops, the command queue fills and then s_tready drops
module fifo_queue_with_cursor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // value [31:0], places [36:32], zero pad above
  input  logic [fqc_pkg::S_DATA_W-1:0] s_tdata,
  // cmd [1:0]
  input  logic [fqc_pkg::CMD_W-1:0]    s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // head_value [31:0], head_valid [32], tail_value [64:33], tail_valid [65],
  // cursor_value [97:66], cursor_valid [98], entry_count [103:99],
  // overflow [104], zero pad above
  output logic [fqc_pkg::M_DATA_W-1:0] m_tdata
);

  // front to queue
  logic         fr_valid;
  logic         fr_ready;
  fqc_pkg::op_t fr_op;

  // queue to back
  logic         bk_valid;
  logic         bk_ready;
  fqc_pkg::op_t bk_op;

  // command decode and jump saturation
  fqc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .op_valid (fr_valid),
    .op_ready (fr_ready),
    .op       (fr_op)
  );

  // decoupling queue between decode and execute
  fqc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_op     (fr_op),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_op    (bk_op)
  );

  // pointer state, element store and result register
  fqc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (bk_valid),
    .op_ready (bk_ready),
    .op       (bk_op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### design/fqc_front.sv
module fqc_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [fqc_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [fqc_pkg::CMD_W-1:0]    s_tuser,
  output logic                         op_valid,
  input  logic                         op_ready,
  output fqc_pkg::op_t                 op
);

  logic [fqc_pkg::PLC_W-1:0] places_in;

  assign places_in = s_tdata[fqc_pkg::VAL_W +: fqc_pkg::PLC_W];

  // decode and saturate the jump distance at the store depth
  always_comb begin
    op.cmd   = fqc_pkg::cmd_t'(s_tuser);
    op.value = fqc_pkg::elem_t'(s_tdata[fqc_pkg::VAL_W-1:0]);
    if (32'(places_in) > 32'(fqc_pkg::DEPTH)) begin
      op.places = fqc_pkg::FULL_CNT;
    end else begin
      op.places = fqc_pkg::cnt_t'(places_in);
    end
  end

  assign op_valid = s_tvalid;
  assign s_tready = op_ready;

endmodule

### design/fqc_queue.sv
module fqc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  fqc_pkg::op_t in_op,
  output logic         out_valid,
  input  logic         out_ready,
  output fqc_pkg::op_t out_op
);

  fqc_pkg::op_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("queue fill out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd1) |-> (wr_ptr != rd_ptr)) else $error("queue pointers disagree with fill");
  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill != 2'd1) |-> (wr_ptr == rd_ptr)) else $error("queue pointers disagree with fill");
`endif

endmodule

### design/fqc_back.sv
module fqc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  fqc_pkg::op_t                 op,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [fqc_pkg::M_DATA_W-1:0] m_tdata
);

  fqc_pkg::elem_t mem [fqc_pkg::DEPTH];

  fqc_pkg::idx_t  head;
  fqc_pkg::idx_t  tail;
  fqc_pkg::cnt_t  count;
  fqc_pkg::idx_t  cur;
  logic           live;
  fqc_pkg::elem_t last_value;

  fqc_pkg::idx_t  head_next;
  fqc_pkg::idx_t  tail_next;
  fqc_pkg::cnt_t  count_next;
  fqc_pkg::idx_t  cur_next;
  logic           live_next;
  fqc_pkg::elem_t last_value_next;
  logic           dropped;
  logic           wr_en;
  fqc_pkg::sum_t  offset;
  fqc_pkg::sum_t  jump_sum;
  fqc_pkg::sum_t  cur_sum;

  // result register
  logic           res_valid;
  fqc_pkg::elem_t rd_head;
  fqc_pkg::elem_t rd_cur;
  fqc_pkg::elem_t res_tail;
  logic           res_any;
  logic           res_live;
  fqc_pkg::cnt_t  res_count;
  logic           res_ovf;

  logic           step;

  assign op_ready = !res_valid || m_tready;
  assign step     = op_valid && op_ready;

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    cur_next        = cur;
    live_next       = live;
    last_value_next = last_value;
    dropped         = 1'b0;
    wr_en           = 1'b0;
    offset          = '0;
    jump_sum        = '0;
    cur_sum         = '0;
    if (step) begin
      unique case (op.cmd)
        fqc_pkg::CMD_ENQ: begin
          if (count == fqc_pkg::FULL_CNT) begin
            dropped = 1'b1;
          end else begin
            wr_en           = 1'b1;
            last_value_next = op.value;
            if (count == '0) begin
              head_next = tail;
              cur_next  = tail;
              live_next = 1'b1;
            end
            tail_next  = fqc_pkg::ring_next(tail);
            count_next = count + fqc_pkg::cnt_t'(1);
          end
        end
        fqc_pkg::CMD_DEQ: begin
          if (count != '0) begin
            head_next  = fqc_pkg::ring_next(head);
            count_next = count - fqc_pkg::cnt_t'(1);
            // cursor sitting on the head follows it, or dies with the last element
            if (live && cur == head) begin
              if (count == fqc_pkg::cnt_t'(1)) begin
                live_next = 1'b0;
              end else begin
                cur_next = fqc_pkg::ring_next(head);
              end
            end
          end
        end
        fqc_pkg::CMD_JUMP: begin
          if (live && op.places != '0) begin
            if (cur >= head) begin
              offset = fqc_pkg::sum_t'(cur) - fqc_pkg::sum_t'(head);
            end else begin
              offset = fqc_pkg::sum_t'(cur) + fqc_pkg::sum_t'(fqc_pkg::DEPTH)
                       - fqc_pkg::sum_t'(head);
            end
            jump_sum = offset + fqc_pkg::sum_t'(op.places);
            cur_sum  = fqc_pkg::sum_t'(cur) + fqc_pkg::sum_t'(op.places);
            if (jump_sum < fqc_pkg::sum_t'(count)) begin
              if (cur_sum >= fqc_pkg::sum_t'(fqc_pkg::DEPTH)) begin
                cur_next = fqc_pkg::idx_t'(cur_sum - fqc_pkg::sum_t'(fqc_pkg::DEPTH));
              end else begin
                cur_next = fqc_pkg::idx_t'(cur_sum);
              end
            end else begin
              live_next = 1'b0;
            end
          end
        end
        fqc_pkg::CMD_QUERY: begin
        end
      endcase
    end
  end

  // store with write-first reads at the updated head and cursor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= op.value;
    end
    if (step) begin
      rd_head    <= (wr_en && tail == head_next) ? op.value : mem[head_next];
      rd_cur     <= (wr_en && tail == cur_next) ? op.value : mem[cur_next];
      res_tail   <= (count_next != '0) ? last_value_next : '0;
      res_any    <= (count_next != '0);
      res_live   <= live_next;
      res_count  <= count_next;
      res_ovf    <= dropped;
      last_value <= last_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cur       <= '0;
      live      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      cur   <= cur_next;
      live  <= live_next;
      if (step) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {
    {fqc_pkg::M_PAD_W{1'b0}},
    res_ovf,
    fqc_pkg::COUNT_W'(res_count),
    res_live,
    res_live ? fqc_pkg::val_t'(rd_cur) : '0,
    res_any,
    fqc_pkg::val_t'(res_tail),
    res_any,
    res_any ? fqc_pkg::val_t'(rd_head) : '0
  };

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fqc_pkg::FULL_CNT) else $error("held count above depth");
  a_live_nonempty: assert property (@(posedge clk) disable iff (rst)
    live |-> (count != '0)) else $error("live cursor on empty store");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ovf) |-> (res_count == fqc_pkg::FULL_CNT))
    else $error("overflow flagged below full");
  a_query_still: assert property (@(posedge clk) disable iff (rst)
    (step && op.cmd == fqc_pkg::CMD_QUERY) |=>
      ($stable(head) && $stable(tail) && $stable(count) && $stable(cur) && $stable(live)))
    else $error("query changed queue state");
`endif

endmodule

### bench/tb_fifo_queue_with_cursor.sv
module tb_fifo_queue_with_cursor;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // value [31:0], places [36:32], zero pad above
  logic [fqc_pkg::S_DATA_W-1:0]   s_tdata = '0;
  // cmd [1:0]
  logic [fqc_pkg::CMD_W-1:0]      s_tuser = fqc_pkg::CMD_QUERY;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // head_value [31:0], head_valid [32], tail_value [64:33], tail_valid [65],
  // cursor_value [97:66], cursor_valid [98], entry_count [103:99],
  // overflow [104], zero pad above
  logic [fqc_pkg::M_DATA_W-1:0]   m_tdata;

  // random idling on both sides, switched off for the closing stretch
  bit idle_on = 1'b1;

  fifo_queue_with_cursor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 time unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // snapshot of the queue as one output item reports it
  typedef struct {
    fqc_pkg::val_t               head_value;
    logic                        head_valid;
    fqc_pkg::val_t               tail_value;
    logic                        tail_valid;
    fqc_pkg::val_t               cursor_value;
    logic                        cursor_valid;
    logic [fqc_pkg::COUNT_W-1:0] entry_count;
    logic                        overflow;
  } queue_view_t;

  // shadow queue with cursor, plus the views still owed by the block
  class queue_scoreboard;
    fqc_pkg::val_t slots[fqc_pkg::DEPTH];
    int            head_ix;
    int            tail_ix;
    int            held;
    int            cursor_ix;
    bit            cursor_on;
    queue_view_t   owed_views[$];
    int            errors;

    function new();
      head_ix = 0;
      tail_ix = 0;
      held = 0;
      cursor_ix = 0;
      cursor_on = 1'b0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return owed_views.size();
    endfunction

    // apply one accepted command to the shadow queue and queue the view it yields
    function void note_command(fqc_pkg::cmd_t op, fqc_pkg::val_t v,
                               logic [fqc_pkg::PLC_W-1:0] places);
      queue_view_t view;
      bit          dropped;
      bit          on_head;
      int          steps;
      int          offset;
      int          last_ix;
      dropped = 1'b0;
      case (op)
        fqc_pkg::CMD_ENQ: begin
          if (held >= fqc_pkg::DEPTH) begin
            dropped = 1'b1;
          end else begin
            slots[tail_ix] = v;
            // first element into an empty queue carries the cursor
            if (held == 0) begin
              head_ix = tail_ix;
              cursor_ix = tail_ix;
              cursor_on = 1'b1;
            end
            tail_ix = (tail_ix + 1) % fqc_pkg::DEPTH;
            held++;
          end
        end
        fqc_pkg::CMD_DEQ: begin
          if (held != 0) begin
            on_head = cursor_on && cursor_ix == head_ix;
            head_ix = (head_ix + 1) % fqc_pkg::DEPTH;
            held--;
            // cursor rides along with the head, dies if nothing is left
            if (on_head) begin
              if (held == 0) cursor_on = 1'b0;
              else cursor_ix = head_ix;
            end
          end
        end
        fqc_pkg::CMD_JUMP: begin
          steps = (int'(places) > fqc_pkg::DEPTH) ? fqc_pkg::DEPTH : int'(places);
          if (cursor_on && steps != 0) begin
            offset = (cursor_ix + fqc_pkg::DEPTH - head_ix) % fqc_pkg::DEPTH;
            if (offset + steps < held) cursor_ix = (cursor_ix + steps) % fqc_pkg::DEPTH;
            else cursor_on = 1'b0;
          end
        end
        default: ;
      endcase
      last_ix = (tail_ix + fqc_pkg::DEPTH - 1) % fqc_pkg::DEPTH;
      view.head_valid   = held != 0;
      view.tail_valid   = held != 0;
      view.head_value   = (held != 0) ? slots[head_ix] : '0;
      view.tail_value   = (held != 0) ? slots[last_ix] : '0;
      view.cursor_valid = cursor_on;
      view.cursor_value = cursor_on ? slots[cursor_ix] : '0;
      view.entry_count  = fqc_pkg::COUNT_W'(held);
      view.overflow     = dropped;
      owed_views.push_back(view);
    endfunction

    function void match_field(string label, logic [fqc_pkg::VAL_W-1:0] want,
                              logic [fqc_pkg::VAL_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
      end
    endfunction

    // compare one output item against the oldest owed view
    function void check_result(logic [fqc_pkg::M_DATA_W-1:0] d);
      queue_view_t want;
      if (owed_views.size() == 0) begin
        errors++;
        $display("%0t: unexpected output item, expected none actual %h", $time, d);
        return;
      end
      want = owed_views.pop_front();
      match_field("head_value",   want.head_value,   d[31:0]);
      match_field("head_valid",   want.head_valid,   d[32]);
      match_field("tail_value",   want.tail_value,   d[64:33]);
      match_field("tail_valid",   want.tail_valid,   d[65]);
      match_field("cursor_value", want.cursor_value, d[97:66]);
      match_field("cursor_valid", want.cursor_valid, d[98]);
      match_field("entry_count",  want.entry_count,  d[103:99]);
      match_field("overflow",     want.overflow,     d[104]);
    endfunction
  endclass

  queue_scoreboard sb = new();

  // both handshakes are sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_command(fqc_pkg::cmd_t'(s_tuser), s_tdata[fqc_pkg::VAL_W-1:0],
                        s_tdata[fqc_pkg::VAL_W+fqc_pkg::PLC_W-1:fqc_pkg::VAL_W]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  // output backpressure: random stall bursts on m_tready
  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_on) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // present one command, with an optional idle burst ahead of it
  task automatic send_cmd(fqc_pkg::cmd_t op, fqc_pkg::val_t v,
                          logic [fqc_pkg::PLC_W-1:0] places);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(fqc_pkg::S_DATA_W-fqc_pkg::PLC_W-fqc_pkg::VAL_W){1'b0}}, places, v};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input back until every owed item has come out
  task automatic drain_outputs();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    // step one edge first so the last accepted command is already noted
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < 5000);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: output stalled, expected %0d more items actual 0", $time, sb.pending());
    end
  endtask

  // mostly plain values, now and then the extremes
  function automatic fqc_pkg::val_t pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // short hops keep the cursor alive, a few overshoot or saturate
  function automatic logic [fqc_pkg::PLC_W-1:0] pick_places();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return fqc_pkg::PLC_W'($urandom_range(0, 4));
    if (r < 19) return fqc_pkg::PLC_W'($urandom_range(0, fqc_pkg::DEPTH));
    return fqc_pkg::PLC_W'($urandom_range(fqc_pkg::DEPTH + 1, 31));
  endfunction

  // enqueue / dequeue weights per phase, so the fill level sweeps empty to full
  int enq_w[7] = '{20, 60, 40, 70, 15, 45, 40};
  int deq_w[7] = '{50, 15, 35, 10, 60, 30, 35};

  initial begin
    int            r;
    fqc_pkg::cmd_t op;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue corner cases
    send_cmd(fqc_pkg::CMD_QUERY, 32'h1234_5678, 5'd3);
    send_cmd(fqc_pkg::CMD_DEQ,   '0,            '0);
    send_cmd(fqc_pkg::CMD_JUMP,  '0,            5'd5);   // cursor not live yet
    send_cmd(fqc_pkg::CMD_ENQ,   '0,            '0);     // places the cursor
    send_cmd(fqc_pkg::CMD_ENQ,   '1,            '1);
    send_cmd(fqc_pkg::CMD_JUMP,  '0,            5'd0);   // zero hop
    send_cmd(fqc_pkg::CMD_JUMP,  '0,            5'd1);   // cursor onto the tail
    send_cmd(fqc_pkg::CMD_DEQ,   '0,            '0);     // head leaves, cursor stays
    send_cmd(fqc_pkg::CMD_DEQ,   '0,            '0);     // head under cursor, queue empties
    send_cmd(fqc_pkg::CMD_ENQ,   32'hA5A5_5A5A, '0);     // cursor comes back
    send_cmd(fqc_pkg::CMD_JUMP,  '0,            5'd2);   // overshoot kills it
    send_cmd(fqc_pkg::CMD_ENQ,   32'h0F0F_F0F0, '0);     // non-empty, cursor stays dead
    repeat (14) send_cmd(fqc_pkg::CMD_ENQ, $urandom, '0);  // fill up
    send_cmd(fqc_pkg::CMD_ENQ,   32'hDEAD_BEEF, '0);     // dropped, overflow
    send_cmd(fqc_pkg::CMD_JUMP,  '0,            5'd31);  // saturating hop, cursor dead

    // random phases with shifting enqueue / dequeue balance
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) idle_on = 1'b0;
      for (int n = 0; n < 250; n++) begin
        r = $urandom_range(0, 99);
        if (r < enq_w[ph]) op = fqc_pkg::CMD_ENQ;
        else if (r < enq_w[ph] + deq_w[ph]) op = fqc_pkg::CMD_DEQ;
        else if (r < 95) op = fqc_pkg::CMD_JUMP;
        else op = fqc_pkg::CMD_QUERY;
        send_cmd(op, pick_value(), pick_places());
      end
      // let the pipeline run dry once mid-run
      if (ph == 2) drain_outputs();
    end

    drain_outputs();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fifo_queue_with_cursor regression: pass");
    end else begin
      $display("fifo_queue_with_cursor regression: fail");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("fifo_queue_with_cursor regression: fail");
    $finish;
  end

endmodule

### filelist.f
design/fqc_pkg.sv
design/fqc_front.sv
design/fqc_queue.sv
design/fqc_back.sv
design/fifo_queue_with_cursor.sv
bench/tb_fifo_queue_with_cursor.sv
